>>> rtl/dlsq_pkg.sv
// ----------------------------------------------------------------------------
// Delta-list sleep queue package
// Shared widths, request and result codes, and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package dlsq_pkg;

  localparam int unsigned NUM_TASKS_DEF = 32;
  localparam int unsigned SLICE_MS      = 10;
  localparam int unsigned TASK_W        = 8;
  localparam int unsigned DELTA_W       = 29;
  localparam int unsigned MS_W          = 32;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned OCC_W         = 6;

  // reciprocal of the slice length: ms / 10 == (ms * SLICE_RECIP) >> SLICE_SHIFT
  // for every 32-bit ms
  localparam logic [MS_W-1:0] SLICE_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned     SLICE_SHIFT = 35;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SLEEP = 2'd1,
    REQ_WAKE  = 2'd2
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SLEPT   = 3'd0,
    KIND_TIMER   = 3'd1,
    KIND_EARLY   = 3'd2,
    KIND_MISSING = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PREV,
    OP_NEXT,
    OP_LOAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [TASK_W-1:0]   ld_task;
    logic [DELTA_W-1:0]  ld_delta;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/delta_list_sleep_queue.sv
// ----------------------------------------------------------------------------
// Delta-list sleep queue
// Sorted timer queue of sleeping tasks kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one request word: a tick, a
// sleep request or an early wake. Output channel (out_valid_o / out_stall_i)
// returns result words; last_o marks the final word of a request.
// One request is worked at a time; in_stall_o is high while it is busy.
// Work per request, with n entries in the queue:
//   tick: bumps the elapsed count; a wake sends one word per task woken.
//   sleep: walks past at most n entries; a reject skips the walk.
//     The slice count comes from a reciprocal multiply by the slice length.
//   early wake: scans up to the task's position, with an extra head fix-up
//     when it was the head; a miss scans all n entries.
// The walks step one cell per cycle through a single read port on the row.
// A finished word sits in the output register, so the next request can be
// taken while the receiver stalls; a pending wake burst waits on the stall.
// Reset empties the queue and clears the elapsed tick count; no clearing
// pass is needed since cells beyond the fill count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_sleep_queue #(
  parameter int unsigned NUM_TASKS = dlsq_pkg::NUM_TASKS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [dlsq_pkg::TASK_W-1:0]       task_id_i,
  input  wire logic [dlsq_pkg::MS_W-1:0]         duration_ms_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [dlsq_pkg::KIND_W-1:0]       kind_o,
  output logic      [dlsq_pkg::TASK_W-1:0]       task_id_res_o,
  output logic      [dlsq_pkg::DELTA_W-1:0]      slices_o,
  output logic                                   last_o,
  output logic      [dlsq_pkg::OCC_W-1:0]        occupancy_o
);

  localparam int unsigned CW = $clog2(NUM_TASKS + 1);
  localparam int unsigned IW = $clog2(NUM_TASKS);
  localparam int unsigned TW = dlsq_pkg::TASK_W;
  localparam int unsigned DW = dlsq_pkg::DELTA_W;
  localparam int unsigned MW = dlsq_pkg::MS_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_CHECK, ST_NORM, ST_WALK, ST_SPLIT, ST_INS,
    ST_SCAN, ST_FOLD, ST_DEL, ST_HEADFIX, ST_TICK, ST_POP, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE, CMD_LOAD, CMD_INS, CMD_DEL
  } cmd_e;

  // control registers
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [DW-1:0]   elapsed_q, elapsed_d;
  logic            out_valid_q, out_valid_d;

  // working registers
  logic [TW-1:0]   id_q, id_d;
  logic [MW-1:0]   ms_q, ms_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   cum_q, cum_d;
  logic [DW-1:0]   dpos_q, dpos_d;
  logic [CW-1:0]   pops_q, pops_d;
  logic [CW-1:0]   final_q, final_d;
  dlsq_pkg::kind_e res_kind_q, res_kind_d;
  logic [DW-1:0]   res_slices_q, res_slices_d;

  // output register
  dlsq_pkg::kind_e out_kind_q, out_kind_d;
  logic [TW-1:0]   out_task_q, out_task_d;
  logic [DW-1:0]   out_slices_q, out_slices_d;
  logic            out_last_q, out_last_d;
  logic [CW-1:0]   out_occ_q, out_occ_d;

  // cell row
  logic [TW-1:0]        cell_task  [NUM_TASKS];
  logic [DW-1:0]        cell_delta [NUM_TASKS];
  dlsq_pkg::cell_ctrl_t cell_ctrl  [NUM_TASKS];

  cmd_e            cmd;
  logic [IW-1:0]   cmd_idx;
  logic [TW-1:0]   ld_task;
  logic [DW-1:0]   ld_delta;
  logic [TW-1:0]   rd_task;
  logic [DW-1:0]   rd_delta;
  logic            out_free;
  logic            dup_hit;
  logic            wake_run;
  logic [CW-1:0]   wake_n;
  logic [2*MW-1:0] div_prod;
  logic [MW-1:0]   quo_x10;
  logic [DW-1:0]   sleep_sl;
  logic [DW-1:0]   scan_sum;
  logic [DW-1:0]   tick_e;

  // build the row; the ends see their own entry as the missing neighbor
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    logic [TW-1:0] prev_task;
    logic [DW-1:0] prev_delta;
    logic [TW-1:0] next_task;
    logic [DW-1:0] next_delta;

    if (g == 0) begin : g_first
      assign prev_task  = cell_task[g];
      assign prev_delta = cell_delta[g];
    end else begin : g_mid_prev
      assign prev_task  = cell_task[g-1];
      assign prev_delta = cell_delta[g-1];
    end

    if (g == NUM_TASKS - 1) begin : g_last
      assign next_task  = cell_task[g];
      assign next_delta = cell_delta[g];
    end else begin : g_mid_next
      assign next_task  = cell_task[g+1];
      assign next_delta = cell_delta[g+1];
    end

    dlsq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[g]),
      .prev_task_i  (prev_task),
      .prev_delta_i (prev_delta),
      .next_task_i  (next_task),
      .next_delta_i (next_delta),
      .task_o       (cell_task[g]),
      .delta_o      (cell_delta[g])
    );
  end

  // read the cell under the walk pointer
  assign rd_task  = cell_task[idx_q[IW-1:0]];
  assign rd_delta = cell_delta[idx_q[IW-1:0]];

  // decode the row command into per-cell operations
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      cell_ctrl[i].ld_task  = ld_task;
      cell_ctrl[i].ld_delta = ld_delta;
      cell_ctrl[i].op       = dlsq_pkg::OP_HOLD;
      case (cmd)
        CMD_LOAD: begin
          if (IW'(i) == cmd_idx) cell_ctrl[i].op = dlsq_pkg::OP_LOAD;
        end
        CMD_INS: begin
          if (IW'(i) > cmd_idx) cell_ctrl[i].op = dlsq_pkg::OP_PREV;
          else if (IW'(i) == cmd_idx) cell_ctrl[i].op = dlsq_pkg::OP_LOAD;
        end
        CMD_DEL: begin
          if (IW'(i) >= cmd_idx) cell_ctrl[i].op = dlsq_pkg::OP_NEXT;
        end
        default: cell_ctrl[i].op = dlsq_pkg::OP_HOLD;
      endcase
    end
  end

  // look for the task among the live entries
  always_comb begin
    dup_hit = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (CW'(i) < count_q && cell_task[i] == id_q) dup_hit = 1'b1;
    end
  end

  // length of the wake run: head plus the zero-delta entries behind it
  always_comb begin
    wake_run = 1'b1;
    wake_n   = CW'(NUM_TASKS);
    for (int i = 1; i < NUM_TASKS; i++) begin
      if (wake_run && !(CW'(i) < count_q && cell_delta[i] == '0)) begin
        wake_n   = CW'(i);
        wake_run = 1'b0;
      end
    end
  end

  // divide by the slice length through its reciprocal
  assign div_prod = (2*MW)'(ms_q) * (2*MW)'(dlsq_pkg::SLICE_RECIP);
  assign quo_x10  = MW'(quo_q) * MW'(dlsq_pkg::SLICE_MS);

  // round up to whole slices, at least one
  assign sleep_sl = (ms_q == '0) ? DW'(1)
                  : quo_q + DW'(ms_q != quo_x10);

  assign scan_sum = cum_q + rd_delta;
  assign tick_e   = elapsed_q + DW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    elapsed_d    = elapsed_q;
    id_d         = id_q;
    ms_d         = ms_q;
    quo_d        = quo_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    cum_d        = cum_q;
    dpos_d       = dpos_q;
    pops_d       = pops_q;
    final_d      = final_q;
    res_kind_d   = res_kind_q;
    res_slices_d = res_slices_q;
    cmd          = CMD_NONE;
    cmd_idx      = idx_q[IW-1:0];
    ld_task      = rd_task;
    ld_delta     = rd_delta;
    out_valid_d  = out_valid_q && out_stall_i;
    out_kind_d   = out_kind_q;
    out_task_d   = out_task_q;
    out_slices_d = out_slices_q;
    out_last_d   = out_last_q;
    out_occ_d    = out_occ_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          id_d  = task_id_i;
          ms_d  = duration_ms_i;
          idx_d = '0;
          cum_d = '0;
          unique case (req_type_i)
            dlsq_pkg::REQ_TICK:  state_d = ST_TICK;
            dlsq_pkg::REQ_SLEEP: state_d = ST_DIV;
            dlsq_pkg::REQ_WAKE:  state_d = ST_SCAN;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        quo_d   = div_prod[dlsq_pkg::SLICE_SHIFT +: DW];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        rem_d        = sleep_sl;
        res_slices_d = sleep_sl;
        if (count_q >= CW'(NUM_TASKS) || dup_hit) begin
          res_kind_d   = dlsq_pkg::KIND_REJECT;
          res_slices_d = '0;
          state_d      = ST_EMIT;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // fold the elapsed ticks into the head
        if (count_q != '0) begin
          cmd      = CMD_LOAD;
          ld_delta = rd_delta - elapsed_q;
        end
        elapsed_d = '0;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        if (idx_q < count_q && rd_delta <= rem_q) begin
          rem_d = rem_q - rd_delta;
          idx_d = idx_q + CW'(1);
        end else begin
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (idx_q < count_q) begin
          cmd      = CMD_LOAD;
          ld_delta = rd_delta - rem_q;
        end
        state_d = ST_INS;
      end
      ST_INS: begin
        cmd        = CMD_INS;
        ld_task    = id_q;
        ld_delta   = rem_q;
        count_d    = count_q + CW'(1);
        res_kind_d = dlsq_pkg::KIND_SLEPT;
        state_d    = ST_EMIT;
      end
      ST_SCAN: begin
        if (idx_q == count_q) begin
          res_kind_d   = dlsq_pkg::KIND_MISSING;
          res_slices_d = '0;
          state_d      = ST_EMIT;
        end else if (rd_task == id_q) begin
          res_kind_d   = dlsq_pkg::KIND_EARLY;
          res_slices_d = scan_sum - elapsed_q;
          dpos_d       = rd_delta;
          pos_d        = idx_q[IW-1:0];
          idx_d        = idx_q + CW'(1);
          state_d      = ST_FOLD;
        end else begin
          cum_d = scan_sum;
          idx_d = idx_q + CW'(1);
        end
      end
      ST_FOLD: begin
        // hand the leaving entry's delta to its successor
        if (idx_q < count_q) begin
          cmd      = CMD_LOAD;
          ld_delta = rd_delta + dpos_q;
        end
        state_d = ST_DEL;
      end
      ST_DEL: begin
        cmd     = CMD_DEL;
        cmd_idx = pos_q;
        count_d = count_q - CW'(1);
        if (pos_q == '0) begin
          idx_d   = '0;
          state_d = ST_HEADFIX;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_HEADFIX: begin
        if (count_q != '0) begin
          cmd      = CMD_LOAD;
          ld_delta = rd_delta - elapsed_q;
        end
        elapsed_d = '0;
        state_d   = ST_EMIT;
      end
      ST_TICK: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else if (tick_e == rd_delta) begin
          elapsed_d = '0;
          pops_d    = wake_n;
          final_d   = count_q - wake_n;
          state_d   = ST_POP;
        end else begin
          elapsed_d = tick_e;
          state_d   = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = dlsq_pkg::KIND_TIMER;
          out_task_d   = rd_task;
          out_slices_d = '0;
          out_last_d   = pops_q == CW'(1);
          out_occ_d    = final_q;
          cmd          = CMD_DEL;
          cmd_idx      = '0;
          count_d      = count_q - CW'(1);
          pops_d       = pops_q - CW'(1);
          if (pops_q == CW'(1)) state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = res_kind_q;
          out_task_d   = id_q;
          out_slices_d = res_slices_q;
          out_last_d   = 1'b1;
          out_occ_d    = count_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // hold state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold working values and the output word
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    ms_q         <= ms_d;
    quo_q        <= quo_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    rem_q        <= rem_d;
    cum_q        <= cum_d;
    dpos_q       <= dpos_d;
    pops_q       <= pops_d;
    final_q      <= final_d;
    res_kind_q   <= res_kind_d;
    res_slices_q <= res_slices_d;
    out_kind_q   <= out_kind_d;
    out_task_q   <= out_task_d;
    out_slices_q <= out_slices_d;
    out_last_q   <= out_last_d;
    out_occ_q    <= out_occ_d;
  end

  assign in_stall_o    = state_q != ST_IDLE;
  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign task_id_res_o = out_task_q;
  assign slices_o      = out_slices_q;
  assign last_o        = out_last_q;
  assign occupancy_o   = dlsq_pkg::OCC_W'(out_occ_q);

endmodule

`default_nettype wire

>>> rtl/dlsq_cell.sv
// ----------------------------------------------------------------------------
// Delta-list cell
// Holds one queue entry and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsq_cell (
  input  wire logic                              clk_i,
  input  wire dlsq_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic [dlsq_pkg::TASK_W-1:0]       prev_task_i,
  input  wire logic [dlsq_pkg::DELTA_W-1:0]      prev_delta_i,
  input  wire logic [dlsq_pkg::TASK_W-1:0]       next_task_i,
  input  wire logic [dlsq_pkg::DELTA_W-1:0]      next_delta_i,
  output logic      [dlsq_pkg::TASK_W-1:0]       task_o,
  output logic      [dlsq_pkg::DELTA_W-1:0]      delta_o
);

  logic [dlsq_pkg::TASK_W-1:0]  task_q,  task_d;
  logic [dlsq_pkg::DELTA_W-1:0] delta_q, delta_d;

  // select the entry for the next cycle
  always_comb begin
    task_d  = task_q;
    delta_d = delta_q;
    case (ctrl_i.op)
      dlsq_pkg::OP_PREV: begin
        task_d  = prev_task_i;
        delta_d = prev_delta_i;
      end
      dlsq_pkg::OP_NEXT: begin
        task_d  = next_task_i;
        delta_d = next_delta_i;
      end
      dlsq_pkg::OP_LOAD: begin
        task_d  = ctrl_i.ld_task;
        delta_d = ctrl_i.ld_delta;
      end
      default: begin
        task_d  = task_q;
        delta_d = delta_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    task_q  <= task_d;
    delta_q <= delta_d;
  end

  assign task_o  = task_q;
  assign delta_o = delta_q;

endmodule

`default_nettype wire

>>> rtl/dlsq_checker.sv
// ----------------------------------------------------------------------------
// Delta-list sleep queue checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dlsq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_stall_i,
  input wire logic [dlsq_pkg::KIND_W-1:0]   kind_i,
  input wire logic [dlsq_pkg::TASK_W-1:0]   task_i,
  input wire logic [dlsq_pkg::DELTA_W-1:0]  slices_i,
  input wire logic                          last_i
);

  // hold a stalled word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(kind_i) && $stable(task_i)
      && $stable(slices_i))
    else $error("stalled result word changed");

  // only a timer wake gives several words per request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != dlsq_pkg::KIND_TIMER |-> last_i)
    else $error("single-word result without last");

  // no slice count on timer wakes, misses and rejects
  a_zero_slices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == dlsq_pkg::KIND_TIMER || kind_i == dlsq_pkg::KIND_MISSING
      || kind_i == dlsq_pkg::KIND_REJECT) |-> slices_i == '0)
    else $error("nonzero slices on a result that carries none");

  // a wake burst runs without gaps once a word is taken
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && kind_i == dlsq_pkg::KIND_TIMER && !last_i
      |=> out_valid_i && kind_i == dlsq_pkg::KIND_TIMER)
    else $error("wake burst broken");

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_i      (kind_o),
  .task_i      (task_id_res_o),
  .slices_i    (slices_o),
  .last_i      (last_o)
);

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Delta-list sleep queue testbench
// Drives ticks, sleep requests and early wakes, predicts every result word
// from a private copy of the queue, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NTASK = dlsq_pkg::NUM_TASKS_DEF;

  typedef struct packed {
    logic [1:0]                   req;
    logic [dlsq_pkg::TASK_W-1:0]  id;
    logic [dlsq_pkg::MS_W-1:0]    ms;
  } req_word_t;

  typedef struct packed {
    logic [dlsq_pkg::KIND_W-1:0]  kind;
    logic [dlsq_pkg::TASK_W-1:0]  id;
    logic [dlsq_pkg::DELTA_W-1:0] slices;
    logic                         last;
    logic [dlsq_pkg::OCC_W-1:0]   occ;
  } res_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] req_type_i = '0;
  logic [dlsq_pkg::TASK_W-1:0] task_id_i = '0;
  logic [dlsq_pkg::MS_W-1:0] duration_ms_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, last_o;
  logic [dlsq_pkg::KIND_W-1:0] kind_o;
  logic [dlsq_pkg::TASK_W-1:0] task_id_res_o;
  logic [dlsq_pkg::DELTA_W-1:0] slices_o;
  logic [dlsq_pkg::OCC_W-1:0] occupancy_o;

  delta_list_sleep_queue u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted queue contents
  logic [dlsq_pkg::TASK_W-1:0]  q_task [NTASK+1];
  logic [dlsq_pkg::DELTA_W-1:0] q_delta [NTASK+1];
  int unsigned                  q_cnt = 0;
  logic [dlsq_pkg::DELTA_W-1:0] q_elapsed = '0;

  req_word_t pending_reqs [$];
  res_word_t expected_results [$];
  int unsigned n_errors = 0;
  bit quiet = 1'b0;
  bit in_taken = 1'b0;

  function automatic int find_slot(logic [dlsq_pkg::TASK_W-1:0] id);
    for (int i = 0; i < q_cnt; i++)
      if (q_task[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < q_cnt; i++) begin
      q_task[i] = q_task[i+1];
      q_delta[i] = q_delta[i+1];
    end
    q_cnt--;
  endfunction

  function automatic void rebase_head();
    if (q_cnt > 0) q_delta[0] = q_delta[0] - q_elapsed;
    q_elapsed = '0;
  endfunction

  // Work out the result words of one request word
  function automatic void predict_queue(req_word_t r);
    res_word_t w [$];
    logic [31:0] s, rem, cum;
    int f, pos;
    w = {};
    case (r.req)
      dlsq_pkg::REQ_TICK: begin
        if (q_cnt != 0) begin
          q_elapsed = q_elapsed + 1'b1;
          if (q_elapsed == q_delta[0]) begin
            q_elapsed = '0;
            w.push_back('{dlsq_pkg::KIND_TIMER, q_task[0], '0, 1'b0, '0});
            drop_slot(0);
            while (q_cnt > 0 && q_delta[0] == 0) begin
              w.push_back('{dlsq_pkg::KIND_TIMER, q_task[0], '0, 1'b0, '0});
              drop_slot(0);
            end
          end
        end
      end
      dlsq_pkg::REQ_SLEEP: begin
        s = r.ms / dlsq_pkg::SLICE_MS + ((r.ms % dlsq_pkg::SLICE_MS) != 0);
        if (s == 0) s = 1;
        if (q_cnt >= NTASK || find_slot(r.id) >= 0) begin
          w.push_back('{dlsq_pkg::KIND_REJECT, r.id, '0, 1'b0, '0});
        end else begin
          rem = s;
          pos = 0;
          rebase_head();
          while (pos < q_cnt && q_delta[pos] <= rem) begin
            rem -= q_delta[pos];
            pos++;
          end
          if (pos < q_cnt) q_delta[pos] = dlsq_pkg::DELTA_W'(q_delta[pos] - rem);
          for (int i = q_cnt; i > pos; i--) begin
            q_task[i] = q_task[i-1];
            q_delta[i] = q_delta[i-1];
          end
          q_task[pos] = r.id;
          q_delta[pos] = rem[dlsq_pkg::DELTA_W-1:0];
          q_cnt++;
          w.push_back('{dlsq_pkg::KIND_SLEPT, r.id, s[dlsq_pkg::DELTA_W-1:0], 1'b0, '0});
        end
      end
      dlsq_pkg::REQ_WAKE: begin
        f = find_slot(r.id);
        if (f < 0) begin
          w.push_back('{dlsq_pkg::KIND_MISSING, r.id, '0, 1'b0, '0});
        end else begin
          cum = 0;
          for (int i = 0; i <= f; i++) cum += q_delta[i];
          cum -= q_elapsed;
          if (f + 1 < q_cnt) q_delta[f+1] = q_delta[f+1] + q_delta[f];
          drop_slot(f);
          if (f == 0) rebase_head();
          w.push_back('{dlsq_pkg::KIND_EARLY, r.id, cum[dlsq_pkg::DELTA_W-1:0], 1'b0, '0});
        end
      end
      default: ;
    endcase
    foreach (w[k]) begin
      w[k].last = (k == w.size() - 1);
      w[k].occ = dlsq_pkg::OCC_W'(q_cnt);
      expected_results.push_back(w[k]);
    end
  endfunction

  // Feed request words at the falling edge; hold a word until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_reqs[0].req;
          task_id_i <= pending_reqs[0].id;
          duration_ms_i <= pending_reqs[0].ms;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 13);
    end
  end

  // Predict on accept, check result words
  always @(posedge clk_i) begin
    res_word_t e;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      predict_queue('{req_type_i, task_id_i, duration_ms_i});
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected: task %0d", task_id_res_o);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, kind_o); n_errors++;
        end
        if (task_id_res_o !== e.id) begin
          $error("task_id_res: expected %0d, actual %0d", e.id, task_id_res_o);
          n_errors++;
        end
        if (slices_o !== e.slices) begin
          $error("slices: expected %0d, actual %0d", e.slices, slices_o); n_errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last_o); n_errors++;
        end
        if (occupancy_o !== e.occ) begin
          $error("occupancy: expected %0d, actual %0d", e.occ, occupancy_o);
          n_errors++;
        end
      end
    end
  end

  function automatic void add_req(logic [1:0] rq, logic [dlsq_pkg::TASK_W-1:0] id,
                                  logic [dlsq_pkg::MS_W-1:0] ms);
    pending_reqs.push_back('{rq, id, ms});
  endfunction

  function automatic logic [dlsq_pkg::MS_W-1:0] rand_ms();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(9);
      default: return $urandom_range(200);
    endcase
  endfunction

  // Stimulus
  initial begin
    int sel;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: empty tick, absent wake, zero and huge durations, rounding,
    // duplicate, wake of an entry behind the head, ignored request type, wake burst
    add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_WAKE, 8'd255, 32'd0);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd255, 32'hFFFF_FFFF);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd7, 32'd11);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd8, 32'd20);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd7, 32'd5);
    add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_SLEEP, 8'd9, 32'd10);
    add_req(dlsq_pkg::REQ_WAKE, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_WAKE, 8'd255, 32'd0);
    add_req(2'd3, 8'hAA, 32'h5555_5555);
    add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    add_req(dlsq_pkg::REQ_WAKE, 8'd8, 32'd0);

    // Fill to capacity, then one more to overflow
    for (int i = 0; i < NTASK + 1; i++)
      add_req(dlsq_pkg::REQ_SLEEP, 8'(8'h40 + i), $urandom_range(60));

    // Random: mostly sleeps and wakes of known ids, plenty of ticks
    for (int i = 0; i < 80; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        add_req(dlsq_pkg::REQ_TICK, 8'($urandom()), $urandom());
      end else if (sel < 70) begin
        add_req(dlsq_pkg::REQ_SLEEP, 8'(8'h40 + $urandom_range(40)), rand_ms());
      end else if (sel < 90) begin
        add_req(dlsq_pkg::REQ_WAKE, 8'(8'h40 + $urandom_range(40)), $urandom());
      end else if (sel < 95) begin
        add_req(dlsq_pkg::REQ_SLEEP, 8'($urandom()), $urandom());
      end else begin
        add_req(2'($urandom_range(3)), 8'($urandom()), $urandom());
      end
      if (i == 60) add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);
    end
    for (int i = 0; i < 40; i++) add_req(dlsq_pkg::REQ_TICK, 8'd0, 32'd0);

    // Stretch with no idling in the middle of the random part
    wait (pending_reqs.size() < 120);
    quiet = 1'b1;
    wait (pending_reqs.size() < 80);
    quiet = 1'b0;

    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
